// ----- hw/rtl/gmp_pkg.sv -----
// ----------------------------------------------------------------------------
// gmp_pkg
// Shared constants, types and arithmetic for the grid minimal path sum core.
// ----------------------------------------------------------------------------
package gmp_pkg;

  localparam int MAX_ROWS   = 128;
  localparam int ROW_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CELL_W     = 16;
  localparam int COST_W     = 32;
  localparam int CFG_W      = 8;
  localparam logic [CFG_W-1:0] ROWS_RESET = CFG_W'(80);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_DOWN,
    ST_UP
  } gmp_state_t;

  // saturating add of a cost and a cell
  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [CELL_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {{(COST_W-CELL_W+1){1'b0}}, b};
    return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/grid_min_path_three_moves_core.sv -----
// ----------------------------------------------------------------------------
// grid_min_path_three_moves_core
// Minimal path sum across a grid moving up, down or right, column relaxation.
// ----------------------------------------------------------------------------
// Cells stream in column by column, top to bottom, one beat per cycle into the
// column memory whenever in_tready is high. The beat that completes a column
// (n rows) starts a downward pass and, for n above one, an upward pass, one
// row per cycle through the single read port of the cost memory. The running
// minimum is kept during the upward pass; after the column flagged by tlast
// the result beat is held in an output register while the next grid loads.
// A completing beat waits until that result has been taken.
module grid_min_path_three_moves_core
  import gmp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // configuration: rows_in_use
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_data,
  // in_tdata: [15:0] cell_value; in_tlast: last_column
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [15:0]       in_tdata,
  input  logic              in_tlast,
  // out_tdata: [31:0] min_path_sum
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata
);

  logic [CELL_W-1:0] cell_mem [MAX_ROWS];
  logic [COST_W-1:0] cost_mem [MAX_ROWS];

  gmp_state_t        state_r, state_nxt;
  logic [CFG_W-1:0]  rows_r;
  logic [ROW_W-1:0]  pos_r, pos_nxt;
  logic              first_r, first_nxt;
  logic              last_r, last_nxt;
  logic [ROW_W-1:0]  nm1_r, nm1_nxt;
  logic [ROW_W-1:0]  cnt_r, cnt_nxt;
  logic              done_r, done_nxt;
  logic              rd_v_r;
  logic [ROW_W-1:0]  rd_addr_r;
  logic [COST_W-1:0] prev_r, prev_nxt;
  logic [COST_W-1:0] best_r, best_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [COST_W-1:0] out_data_r, out_data_nxt;
  logic [CELL_W-1:0] cell_rd_r;
  logic [COST_W-1:0] cost_rd_r;

  logic              issue_v;
  logic [ROW_W-1:0]  issue_addr;
  logic              cost_we;
  logic [COST_W-1:0] cost_wdata;
  logic [ROW_W-1:0]  nm1_eff;
  logic              completes;
  logic              in_acc;
  logic [COST_W-1:0] down_base, down_cand, down_val;
  logic [COST_W-1:0] up_cand, up_val;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    if (rows_r == '0) begin
      nm1_eff = '0;
    end else if (32'(rows_r) > 32'(MAX_ROWS)) begin
      nm1_eff = ROW_W'(MAX_ROWS - 1);
    end else begin
      nm1_eff = ROW_W'(rows_r - CFG_W'(1));
    end
  end

  assign completes = (pos_r >= nm1_eff);
  assign in_tready = (state_r == ST_LOAD) && !(completes && out_valid_r);
  assign in_acc    = in_tvalid && in_tready;

  assign down_base = first_r ? {{(COST_W-CELL_W){1'b0}}, cell_rd_r}
                             : sat_add(cost_rd_r, cell_rd_r);
  assign down_cand = sat_add(prev_r, cell_rd_r);
  assign down_val  = ((rd_addr_r != '0) && (down_cand < down_base)) ? down_cand : down_base;
  assign up_cand   = sat_add(prev_r, cell_rd_r);
  assign up_val    = (up_cand < cost_rd_r) ? up_cand : cost_rd_r;

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    nm1_nxt       = nm1_r;
    cnt_nxt       = cnt_r;
    done_nxt      = done_r;
    prev_nxt      = prev_r;
    best_nxt      = best_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    issue_v       = 1'b0;
    issue_addr    = cnt_r;
    cost_we       = 1'b0;
    cost_wdata    = down_val;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (completes) begin
            pos_nxt   = '0;
            nm1_nxt   = nm1_eff;
            last_nxt  = in_tlast;
            cnt_nxt   = '0;
            done_nxt  = 1'b0;
            state_nxt = ST_DOWN;
          end else begin
            pos_nxt = pos_r + ROW_W'(1);
          end
        end
      end
      ST_DOWN: begin
        if (!done_r) begin
          issue_v = 1'b1;
          if (cnt_r == nm1_r) begin
            done_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r + ROW_W'(1);
          end
        end
        if (rd_v_r) begin
          cost_we    = 1'b1;
          cost_wdata = down_val;
          prev_nxt   = down_val;
          if (rd_addr_r == nm1_r) begin
            best_nxt = down_val;
            if (nm1_r == '0) begin
              state_nxt = ST_LOAD;
              if (last_r) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = down_val;
                first_nxt     = 1'b1;
              end else begin
                first_nxt = 1'b0;
              end
            end else begin
              state_nxt = ST_UP;
              cnt_nxt   = nm1_r - ROW_W'(1);
              done_nxt  = 1'b0;
            end
          end
        end
      end
      ST_UP: begin
        if (!done_r) begin
          issue_v = 1'b1;
          if (cnt_r == '0) begin
            done_nxt = 1'b1;
          end else begin
            cnt_nxt = cnt_r - ROW_W'(1);
          end
        end
        if (rd_v_r) begin
          cost_we    = 1'b1;
          cost_wdata = up_val;
          prev_nxt   = up_val;
          best_nxt   = (up_val < best_r) ? up_val : best_r;
          if (rd_addr_r == '0) begin
            state_nxt = ST_LOAD;
            if (last_r) begin
              out_valid_nxt = 1'b1;
              out_data_nxt  = best_nxt;
              first_nxt     = 1'b1;
            end else begin
              first_nxt = 1'b0;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      rows_r      <= ROWS_RESET;
      pos_r       <= '0;
      first_r     <= 1'b1;
      done_r      <= 1'b1;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      first_r     <= first_nxt;
      done_r      <= done_nxt;
      rd_v_r      <= issue_v;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        rows_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    last_r     <= last_nxt;
    nm1_r      <= nm1_nxt;
    cnt_r      <= cnt_nxt;
    prev_r     <= prev_nxt;
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
    rd_addr_r  <= issue_addr;
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cell_mem[pos_r] <= in_tdata;
    end
    if (issue_v) begin
      cell_rd_r <= cell_mem[issue_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cost_we) begin
      cost_mem[rd_addr_r] <= cost_wdata;
    end
    if (issue_v) begin
      cost_rd_r <= cost_mem[issue_addr];
    end
  end

endmodule

// ----- hw/rtl/gmp_checker.sv -----
// ----------------------------------------------------------------------------
// gmp_checker
// Port-level checks for the grid minimal path sum core, bound to the top.
// ----------------------------------------------------------------------------
module gmp_checker
  import gmp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [31:0]       out_tdata
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared one cycle after an input beat");

  a_busy_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("input taken during the relaxation passes");

endmodule

bind grid_min_path_three_moves_core gmp_checker u_gmp_checker (.*);

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Streams whole grids and broken-off columns into the minimal path sum core
// under several row counts and handshake pressures. A tracker class predicts
// every sum from the accepted cells and checks each result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import gmp_pkg::*;

  localparam int SETTLE_CYCLES = 4 * MAX_ROWS + 16;
  localparam int PHASES        = 24;
  localparam int PHASE_CELLS   = 50;

  class min_path_tracker;
    logic [CFG_W-1:0]  rows_cfg;
    logic [COST_W-1:0] cost [MAX_ROWS];
    logic [CELL_W-1:0] cells [MAX_ROWS];
    int                pos;
    bit                first_col;
    int                rows_written;
    logic [COST_W-1:0] expected_sums [$];
    int                errors;

    function new();
      rows_cfg     = ROWS_RESET;
      pos          = 0;
      first_col    = 1'b1;
      rows_written = 0;
      errors       = 0;
      foreach (cost[r]) begin
        cost[r]  = '0;
        cells[r] = '0;
      end
    endfunction

    function int rows_for(logic [CFG_W-1:0] v);
      if (v == 0) return 1;
      if (int'(v) > MAX_ROWS) return MAX_ROWS;
      return int'(v);
    endfunction

    function logic [COST_W-1:0] add_sat(logic [COST_W-1:0] a, logic [CELL_W-1:0] b);
      logic [COST_W:0] s;
      s = {1'b0, a} + {{(COST_W - CELL_W + 1){1'b0}}, b};
      return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
    endfunction

    function void note_rows(logic [CFG_W-1:0] v);
      rows_cfg = v;
    endfunction

    function void note_cell(logic [CELL_W-1:0] cell_val, logic mark);
      int                n;
      logic [COST_W-1:0] c;
      logic [COST_W-1:0] best;
      n = rows_for(rows_cfg);
      if (pos < MAX_ROWS) cells[pos] = cell_val;
      pos++;
      if (pos < n) return;
      for (int r = 0; r < n; r++)
        cost[r] = first_col ? COST_W'(cells[r]) : add_sat(cost[r], cells[r]);
      for (int r = 1; r < n; r++) begin
        c = add_sat(cost[r-1], cells[r]);
        if (c < cost[r]) cost[r] = c;
      end
      for (int r = n - 1; r > 0; r--) begin
        c = add_sat(cost[r], cells[r-1]);
        if (c < cost[r-1]) cost[r-1] = c;
      end
      if (n > rows_written) rows_written = n;
      pos = 0;
      if (!mark) begin
        first_col = 1'b0;
        return;
      end
      best = '1;
      for (int r = 0; r < n; r++)
        if (cost[r] < best) best = cost[r];
      first_col = 1'b1;
      expected_sums = {expected_sums, best};
    endfunction

    function void check_sum(logic [COST_W-1:0] got);
      logic [COST_W-1:0] want;
      if (expected_sums.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sum beat: got 0x%08h", got);
        return;
      end
      want = expected_sums.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("sum mismatch: expected 0x%08h, got 0x%08h", want, got);
      end
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data   = '0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [15:0]       in_tdata   = '0;
  logic              in_tlast   = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;

  bit                in_fire, out_fire, cfg_fire;
  logic [CELL_W-1:0] seen_cell;
  logic              seen_mark;
  logic [COST_W-1:0] seen_sum;
  logic [CFG_W-1:0]  seen_rows;
  int                send_idle_pct = 0;
  int                stall_pct     = 0;

  min_path_tracker tracker = new();

  grid_min_path_three_moves_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] cell_value
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)   // [31:0] min_path_sum
  );

  always #5 clk = ~clk;

  // sample handshakes mid-cycle, act on them at the next rising edge
  always @(negedge clk) begin
    in_fire   = rst_n && in_tvalid && in_tready;
    out_fire  = rst_n && out_tvalid && out_tready;
    cfg_fire  = rst_n && cfg_valid && cfg_ready;
    seen_cell = in_tdata;
    seen_mark = in_tlast;
    seen_sum  = out_tdata;
    seen_rows = cfg_data;
  end

  always @(posedge clk) begin
    if (cfg_fire) tracker.note_rows(seen_rows);
    if (in_fire) tracker.note_cell(seen_cell, seen_mark);
    if (out_fire) tracker.check_sum(seen_sum);
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #(5_000_000);
    $display("** grid_min_path_three_moves_core: FAILED **");
    $finish;
  end

  task automatic send_cell(input logic [CELL_W-1:0] cell_val, input logic mark);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cell_val;
    in_tlast  <= mark;
    do @(posedge clk); while (!in_fire);
  endtask

  task automatic write_rows(input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_fire);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drain all sums, then let any relaxation pass finish
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_pressure(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 72; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 72; end
      default: begin send_idle_pct = 32; stall_pct = 32; end
    endcase
  endtask

  function automatic logic [CELL_W-1:0] rand_cell();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return CELL_W'($urandom_range(0, 20));
      default: return CELL_W'($urandom);
    endcase
  endfunction

  task automatic run_grids(input int budget, input bit may_break);
    int   n, pos, col, ncols, sent;
    bit   completing;
    logic mark;
    n     = tracker.rows_for(tracker.rows_cfg);
    pos   = tracker.pos;
    col   = 0;
    ncols = 1;
    sent  = 0;
    while (!(sent >= budget && (may_break || (pos == 0 && col == 0)))) begin
      if (pos == 0 && col == 0)
        ncols = (n > 32) ? $urandom_range(1, 2) : $urandom_range(1, 5);
      completing = (pos + 1 >= n);
      mark = completing ? (col + 1 >= ncols) : ($urandom_range(99) < 20);
      send_cell(rand_cell(), mark);
      sent++;
      if (!completing) pos++;
      else begin
        pos = 0;
        col = mark ? 0 : col + 1;
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] rows_plan [8] = '{8'd80, 8'd255, 8'd1, 8'd0, 8'd128, 8'd2,
                                        8'd129, 8'd5};
    logic [CFG_W-1:0] v;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_pressure(0);
    write_rows(8'd1);
    send_cell(16'd0, 1'b1);
    send_cell(16'hFFFF, 1'b1);
    send_cell(16'd5, 1'b0);
    send_cell(16'd7, 1'b1);
    settle();
    write_rows(8'd3);
    send_cell(16'd5, 1'b0);
    send_cell(16'd9, 1'b1);
    send_cell(16'd1, 1'b0);
    send_cell(16'd1, 1'b1);
    send_cell(16'd100, 1'b0);
    send_cell(16'd2, 1'b1);
    settle();
    write_rows(8'd0);
    send_cell(16'd3, 1'b1);
    send_cell(16'hFFFF, 1'b0);
    send_cell(16'hFFFF, 1'b1);
    settle();
    write_rows(8'd4);
    send_cell(16'd4, 1'b0);
    send_cell(16'd6, 1'b0);
    send_cell(16'd8, 1'b0);
    settle();
    write_rows(8'd2);
    send_cell(16'd10, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      set_pressure(p % 4);
      if (p < 8) v = rows_plan[p];
      else if ($urandom_range(9) == 0) v = CFG_W'($urandom_range(0, 255));
      else v = CFG_W'($urandom_range(1, 12));
      // grow only where no unwritten row cost can be read
      if (!tracker.first_col && tracker.rows_for(v) > tracker.rows_written)
        v = CFG_W'($urandom_range(1, tracker.rows_written));
      write_rows(v);
      run_grids(PHASE_CELLS, p >= 8 && $urandom_range(2) == 0);
    end

    settle();
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("** grid_min_path_three_moves_core: PASSED **");
    else
      $display("** grid_min_path_three_moves_core: FAILED **");
    $finish;
  end

endmodule
